// ===== design/mesh_replay_protection_list_unit_defines.svh =====
// Assertion macros shared by the replay protection list RTL.
`ifndef MESH_REPLAY_PROTECTION_LIST_UNIT_DEFINES_SVH
`define MESH_REPLAY_PROTECTION_LIST_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define MRPL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define MRPL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/mrpl_pkg.sv =====
// Package with the types and constants of the replay protection list.
package mrpl_pkg;

    localparam int ENTRIES = 32;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int SLOT_W  = 5;
    localparam int ADDR_W  = 16;
    localparam int SEQ_W   = 24;

    localparam logic [2:0] FUNC_CHECK_UPDATE = 3'd0;
    localparam logic [2:0] FUNC_CHECK_ONLY   = 3'd1;
    localparam logic [2:0] FUNC_UPDATE       = 3'd2;
    localparam logic [2:0] FUNC_IV_RESET     = 3'd3;
    localparam logic [2:0] FUNC_CLEAR        = 3'd4;

    typedef struct packed {
        logic [2:0]        func;
        logic [ADDR_W-1:0] src_addr;
        logic [SEQ_W-1:0]  seq_num;
        logic              msg_old_iv;
        logic              is_local;
        logic              to_node;
        logic              bridge;
        logic [SLOT_W-1:0] slot_in;
    } req_t;

    typedef struct packed {
        logic              replay;
        logic              slot_found;
        logic [SLOT_W-1:0] slot_out;
        logic              table_full;
        logic              seg_reset;
    } rsp_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [SEQ_W-1:0]  seq;
        logic              old_iv;
    } entry_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_SHIFT,
        CELL_LOAD,
        CELL_CLEAR,
        CELL_MARK,
        CELL_PACK
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     sel;
    } cell_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_MARK,
        ST_PACK,
        ST_CLEAR
    } state_t;

endpackage

// ===== design/mrpl_cell.sv =====
// One table slot of the replay protection list, linked to its right neighbor.
module mrpl_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  mrpl_pkg::cell_ctrl_t ctrl,
    input  mrpl_pkg::entry_t    right_in,
    input  mrpl_pkg::entry_t    load_in,
    input  logic                empty_in,
    output logic                empty_out,
    output logic                seg_flag,
    output mrpl_pkg::entry_t    entry_out
);

    mrpl_pkg::entry_t entry_reg;
    mrpl_pkg::entry_t entry_next;
    logic             self_empty;

    assign self_empty = (entry_reg.addr == '0);
    // An empty slot at or left of this one means this slot pulls from the right.
    assign empty_out  = empty_in | self_empty;
    assign seg_flag   = (ctrl.op == mrpl_pkg::CELL_LOAD) && ctrl.sel
                        && entry_reg.old_iv && !load_in.old_iv;
    assign entry_out  = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        case (ctrl.op)
            mrpl_pkg::CELL_HOLD:
            begin
                entry_next = entry_reg;
            end
            mrpl_pkg::CELL_SHIFT:
            begin
                entry_next = right_in;
            end
            mrpl_pkg::CELL_LOAD:
            begin
                if (ctrl.sel)
                begin
                    entry_next = load_in;
                end
            end
            mrpl_pkg::CELL_CLEAR:
            begin
                entry_next = '0;
            end
            mrpl_pkg::CELL_MARK:
            begin
                if (self_empty || entry_reg.old_iv)
                begin
                    entry_next = '0;
                end
                else
                begin
                    entry_next.old_iv = 1'b1;
                end
            end
            mrpl_pkg::CELL_PACK:
            begin
                if (empty_out)
                begin
                    entry_next = right_in;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

endmodule

// ===== design/mesh_replay_protection_list_unit.sv =====
// Top level of the replay protection list: command FSM around a ring of slot cells.
// A check scans every slot before the done strobe; an IV reset marks the table and then
// packs it; an update or clear passes through a single state; a filtered or ignored item is answered from idle.
// One item at a time; start is taken again in the cycle the done strobe is shown.
// The rate is set by the ring of cells, which rotates one slot past cell 0 a cycle during a scan.
// Asynchronous active-low reset empties every slot and returns the FSM to idle.
// The result is shown for one cycle with done high; the receiver cannot stall it.
`include "mesh_replay_protection_list_unit_defines.svh"

module mesh_replay_protection_list_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  mrpl_pkg::req_t cmd,
    output logic           done,
    output mrpl_pkg::rsp_t rsp
);

    localparam int N = mrpl_pkg::ENTRIES;

    // Control state.
    mrpl_pkg::state_t state_reg, state_next;
    logic [mrpl_pkg::IDX_W-1:0] cnt_reg, cnt_next;
    logic                       hit_reg, hit_next;
    logic                       done_reg, done_next;

    // The accepted item, the scan result gathered so far, and the shown result.
    mrpl_pkg::req_t req_reg, req_next;
    mrpl_pkg::rsp_t acc_reg, acc_next;
    mrpl_pkg::rsp_t rsp_reg, rsp_next;

    // Cell ring.
    mrpl_pkg::entry_t   cell_entry [N];
    mrpl_pkg::entry_t   cell_right [N];
    logic [N-1:0]       cell_empty;
    logic [N-1:0]       cell_seg;
    logic [N-1:0]       cell_sel;
    mrpl_pkg::cell_op_t cell_op;
    mrpl_pkg::entry_t   new_entry;
    mrpl_pkg::entry_t   tail_in;

    // Scan step signals, looking at the slot that sits in cell 0.
    mrpl_pkg::entry_t head;
    logic             accept;
    logic             gated;
    logic             last_step;
    logic             scan_active;
    logic             head_empty;
    logic             head_match;
    logic             step_hit;
    logic             step_found;
    logic             write_now;
    logic             step_segr;

    assign accept = start && !busy;
    assign busy   = (state_reg != mrpl_pkg::ST_IDLE);
    assign done   = done_reg;
    assign rsp    = rsp_reg;

    // Only traffic from the network that is addressed here or bridged is checked.
    assign gated = !cmd.is_local && (cmd.to_node || cmd.bridge);

    assign new_entry.addr   = req_reg.src_addr;
    assign new_entry.seq    = req_reg.seq_num;
    assign new_entry.old_iv = req_reg.msg_old_iv;

    assign head        = cell_entry[0];
    assign last_step   = (cnt_reg == mrpl_pkg::IDX_W'(N - 1));
    assign scan_active = (state_reg == mrpl_pkg::ST_SCAN) && !hit_reg;
    assign head_empty  = (head.addr == '0);
    assign head_match  = (head.addr == req_reg.src_addr);
    assign step_hit    = scan_active && (head_empty || head_match);

    // A matching slot is usable unless an old-IV message meets a new-IV entry or
    // the sequence number did not grow within the same IV.
    assign step_found = scan_active && (head_empty
                        || (head_match
                            && !(req_reg.msg_old_iv && !head.old_iv)
                            && ((!req_reg.msg_old_iv && head.old_iv)
                                || (head.seq < req_reg.seq_num))));
    assign write_now  = step_found && (req_reg.func == mrpl_pkg::FUNC_CHECK_UPDATE);
    assign step_segr  = write_now && head.old_iv && !req_reg.msg_old_iv;

    // During a scan the slot leaving cell 0 re-enters at the tail, replaced by
    // the new entry when the check writes it. Packing shifts empties in.
    always_comb
    begin
        if (state_reg == mrpl_pkg::ST_PACK)
        begin
            tail_in = '0;
        end
        else if (write_now)
        begin
            tail_in = new_entry;
        end
        else
        begin
            tail_in = head;
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        mrpl_pkg::cell_ctrl_t ctrl;

        assign cell_sel[i] = (32'(req_reg.slot_in) == i);
        assign ctrl.op     = cell_op;
        assign ctrl.sel    = cell_sel[i];

        if (i == N - 1)
        begin : g_tail
            assign cell_right[i] = tail_in;
        end
        else
        begin : g_body
            assign cell_right[i] = cell_entry[i+1];
        end

        mrpl_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .right_in  (cell_right[i]),
            .load_in   (new_entry),
            .empty_in  ((i == 0) ? 1'b0 : cell_empty[(i == 0) ? 0 : i-1]),
            .empty_out (cell_empty[i]),
            .seg_flag  (cell_seg[i]),
            .entry_out (cell_entry[i])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        hit_next   = hit_reg;
        done_next  = 1'b0;
        req_next   = req_reg;
        acc_next   = acc_reg;
        rsp_next   = rsp_reg;
        cell_op    = mrpl_pkg::CELL_HOLD;

        case (state_reg)
            mrpl_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    req_next = cmd;
                    acc_next = '0;
                    hit_next = 1'b0;
                    cnt_next = '0;
                    case (cmd.func)
                        mrpl_pkg::FUNC_CHECK_UPDATE, mrpl_pkg::FUNC_CHECK_ONLY:
                        begin
                            if (gated)
                            begin
                                state_next = mrpl_pkg::ST_SCAN;
                            end
                            else
                            begin
                                rsp_next  = '0;
                                done_next = 1'b1;
                            end
                        end
                        mrpl_pkg::FUNC_UPDATE:
                        begin
                            if (32'(cmd.slot_in) < N)
                            begin
                                state_next = mrpl_pkg::ST_UPDATE;
                            end
                            else
                            begin
                                rsp_next  = '0;
                                done_next = 1'b1;
                            end
                        end
                        mrpl_pkg::FUNC_IV_RESET:
                        begin
                            state_next = mrpl_pkg::ST_MARK;
                        end
                        mrpl_pkg::FUNC_CLEAR:
                        begin
                            state_next = mrpl_pkg::ST_CLEAR;
                        end
                        default:
                        begin
                            rsp_next  = '0;
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            mrpl_pkg::ST_SCAN:
            begin
                cell_op  = mrpl_pkg::CELL_SHIFT;
                cnt_next = cnt_reg + 1'b1;
                if (step_hit)
                begin
                    hit_next            = 1'b1;
                    acc_next.replay     = !step_found;
                    acc_next.slot_found = step_found;
                    acc_next.slot_out   = step_found ? mrpl_pkg::SLOT_W'(cnt_reg) : '0;
                    acc_next.table_full = 1'b0;
                    acc_next.seg_reset  = step_segr;
                end
                if (last_step)
                begin
                    state_next = mrpl_pkg::ST_IDLE;
                    done_next  = 1'b1;
                    rsp_next   = acc_next;
                    if (!hit_next)
                    begin
                        rsp_next            = '0;
                        rsp_next.replay     = 1'b1;
                        rsp_next.table_full = 1'b1;
                    end
                end
            end
            mrpl_pkg::ST_UPDATE:
            begin
                cell_op             = mrpl_pkg::CELL_LOAD;
                rsp_next            = '0;
                rsp_next.slot_found = 1'b1;
                rsp_next.slot_out   = req_reg.slot_in;
                rsp_next.seg_reset  = |cell_seg;
                done_next           = 1'b1;
                state_next          = mrpl_pkg::ST_IDLE;
            end
            mrpl_pkg::ST_MARK:
            begin
                cell_op    = mrpl_pkg::CELL_MARK;
                cnt_next   = '0;
                state_next = mrpl_pkg::ST_PACK;
            end
            mrpl_pkg::ST_PACK:
            begin
                // Each cycle closes the leftmost gap, so the pass packs any table.
                cell_op  = mrpl_pkg::CELL_PACK;
                cnt_next = cnt_reg + 1'b1;
                if (last_step)
                begin
                    rsp_next   = '0;
                    done_next  = 1'b1;
                    state_next = mrpl_pkg::ST_IDLE;
                end
            end
            mrpl_pkg::ST_CLEAR:
            begin
                cell_op    = mrpl_pkg::CELL_CLEAR;
                rsp_next   = '0;
                done_next  = 1'b1;
                state_next = mrpl_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = mrpl_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mrpl_pkg::ST_IDLE;
            cnt_reg   <= '0;
            hit_reg   <= 1'b0;
            done_reg  <= 1'b0;
            rsp_reg   <= '0;
            acc_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            hit_reg   <= hit_next;
            done_reg  <= done_next;
            rsp_reg   <= rsp_next;
            acc_reg   <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
    end

    // The result strobe only appears once the FSM is back in idle.
    `MRPL_ASSERT_NOW(a_done_when_idle, done_reg, state_reg == mrpl_pkg::ST_IDLE,
        "result strobe while an item is still in work")
    // A full table is always reported as a rejection.
    `MRPL_ASSERT_NOW(a_full_rejects, done_reg && rsp_reg.table_full, rsp_reg.replay,
        "table full reported without replay")
    // No usable slot means the slot index reads as zero and no segment reset is flagged.
    `MRPL_ASSERT_NOW(a_slot_zero, done_reg && !rsp_reg.slot_found,
        rsp_reg.slot_out == '0 && !rsp_reg.seg_reset,
        "slot index or segment reset set without a usable slot")
    // An accepted item either keeps the block busy or finishes at once.
    `MRPL_ASSERT_NEXT(a_accept_progress, start && !busy, busy || done_reg,
        "accepted item neither started nor finished")

endmodule
